FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the tail cancellation filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle once the antecedent is true.
`define ETCF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after the antecedent.
`define ETCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/etcf_pkg.sv
package etcf_pkg;

  localparam int ADC_W      = 10;
  localparam int VAL_W      = 20;
  localparam int REM_W      = 32;
  localparam int FAC_W      = 16;
  localparam int THR_W      = 19;
  localparam int TBIN_W     = 6;
  localparam int NUM_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int TERMS      = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM_EXP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE_ONE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE_TWO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COEF_ONE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COEF_TWO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 3'd6;

  // Register values after reset.
  localparam logic             RST_ENABLE    = 1'b1;
  localparam logic [NUM_W-1:0] RST_NUM_EXP   = 2'd2;
  localparam logic [FAC_W-1:0] RST_RATE_ONE  = 16'd60104;
  localparam logic [FAC_W-1:0] RST_RATE_TWO  = 16'd30370;
  localparam logic [FAC_W-1:0] RST_COEF_ONE  = 16'd7471;
  localparam logic [FAC_W-1:0] RST_COEF_TWO  = 16'd40894;
  localparam logic [THR_W-1:0] RST_THRESHOLD = 19'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TERM,
    ST_DECAY
  } etcf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the input item and form the corrected value
    logic term;   // add coefficient times corrected value to each remainder
    logic push;   // move the result into the output register
    logic decay;  // scale each remainder by its rate
  } etcf_cmd_t;

  typedef struct packed {
    logic out_free;
  } etcf_status_t;

endpackage

FILE: src/etcf_ifs.sv
interface etcf_in_if import etcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  logic             last_in_pad;

  modport source (output valid, adc_sample, last_in_pad, input ready);
  modport sink   (input valid, adc_sample, last_in_pad, output ready);
endinterface

interface etcf_out_if import etcf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] filtered_value;
  logic [TBIN_W-1:0]       time_bin;
  logic                    above_threshold;
  logic                    last_out;

  modport source (output valid, filtered_value, time_bin, above_threshold, last_out,
                  input ready);
  modport sink   (input valid, filtered_value, time_bin, above_threshold, last_out,
                  output ready);
endinterface

interface etcf_cfg_if import etcf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

FILE: src/exp_tail_cancellation_filter.sv
// Exponential tail cancellation filter for pad ADC samples. Each input item is one raw
// 10-bit sample of a pad in time order, with a flag on the last sample of the pad. The
// sample is doubled into Q16.4 and, when cancellation is enabled, the rounded sum of up
// to two exponential remainders is subtracted and the result saturated to 20 bits. Each
// remainder then takes in its coefficient times that value and decays by its rate; both
// are cleared after the last sample of a pad. Every item yields exactly one result item
// carrying the corrected value, its time bin within the pad, a flag for a value strictly
// above the threshold and a copy of the last flag. An item passes three states: it is
// accepted in the idle state, where the corrected value is formed, then the term state
// multiplies by the coefficients and the decay state multiplies by the rates. The next
// item needs the remainders that the rate multiply leaves, so no new item is taken until
// the decay state is done. A finished result sits in an output register, so the
// next item is taken while it waits; if the output register is still full when the next
// result is ready, the block holds that result until the register empties. The
// configuration port accepts a write in every cycle; writes go to the register whose
// index is given (0 enable, 1 term count, 2 and 3 rates, 4 and 5 coefficients,
// 6 threshold), an index beyond these is ignored, and writes belong in idle periods.
module exp_tail_cancellation_filter import etcf_pkg::*; #(
  parameter int MAX_TIME_BINS = 64
) (
  input logic         clk,
  input logic         rst_n,
  etcf_in_if.sink     in_ch,
  etcf_out_if.source  out_ch,
  etcf_cfg_if.sink    cfg_ch
);

  etcf_cmd_t    cmd;
  etcf_status_t status;
  logic         in_ready;

  // Configuration registers are plain flops, so the write port never stalls.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  etcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  etcf_dp #(
    .MAX_TIME_BINS (MAX_TIME_BINS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_adc_sample       (in_ch.adc_sample),
    .in_last_in_pad      (in_ch.last_in_pad),
    .cfg_we              (cfg_ch.valid),
    .cfg_index           (cfg_ch.reg_index),
    .cfg_data            (cfg_ch.data),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_filtered_value  (out_ch.filtered_value),
    .out_time_bin        (out_ch.time_bin),
    .out_above_threshold (out_ch.above_threshold),
    .out_last_out        (out_ch.last_out)
  );

endmodule

FILE: src/etcf_ctrl.sv
`include "assert_macros.svh"

module etcf_ctrl import etcf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  etcf_status_t status,
  output etcf_cmd_t    cmd
);

  etcf_state_t state_r;
  etcf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        // The result leaves for the output register only when that slot is free.
        if (status.out_free) begin
          cmd.term  = 1'b1;
          cmd.push  = 1'b1;
          state_nxt = ST_DECAY;
        end
      end
      ST_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `ETCF_ASSERT_NEXT(a_accept_to_term, clk, rst_n, in_valid && in_ready, state_r == ST_TERM,
    "accepted item did not move to the term step")
  `ETCF_ASSERT_SAME(a_push_needs_room, clk, rst_n, cmd.push, status.out_free,
    "result pushed into a full output register")
  `ETCF_ASSERT_NEXT(a_decay_to_idle, clk, rst_n, state_r == ST_DECAY, state_r == ST_IDLE,
    "decay step not followed by idle")

endmodule

FILE: src/etcf_dp.sv
`include "assert_macros.svh"

module etcf_dp import etcf_pkg::*; #(
  parameter int MAX_TIME_BINS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  etcf_cmd_t               cmd,
  output etcf_status_t            status,
  input  logic [ADC_W-1:0]        in_adc_sample,
  input  logic                    in_last_in_pad,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_filtered_value,
  output logic [TBIN_W-1:0]       out_time_bin,
  output logic                    out_above_threshold,
  output logic                    out_last_out
);

  localparam int CW = $clog2(MAX_TIME_BINS);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [REM_W-1:0] REM_MAX = {1'b0, {(REM_W-1){1'b1}}};
  localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

  // Configuration registers.
  logic             enable_r;
  logic [NUM_W-1:0] num_exp_r;
  logic [FAC_W-1:0] rate_r [TERMS];
  logic [FAC_W-1:0] coef_r [TERMS];
  logic [THR_W-1:0] thr_r;

  // Filter state.
  logic signed [REM_W-1:0] rem_r [TERMS];
  logic signed [REM_W:0]   t_r   [TERMS];
  logic [CW-1:0]           cnt_r;

  // Item in flight.
  logic signed [VAL_W-1:0] res_r;
  logic [TBIN_W-1:0]       tbin_r;
  logic                    last_r;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [TBIN_W-1:0]       out_tbin_r;
  logic                    out_above_r;
  logic                    out_last_r;

  logic                    use_term [TERMS];
  logic signed [REM_W:0]   corr;
  logic signed [REM_W+1:0] corr_sum;
  logic signed [25:0]      corr_rnd;
  logic signed [26:0]      gained;
  logic signed [26:0]      diff;
  logic signed [VAL_W-1:0] res;
  logic [CW+TBIN_W-1:0]    cnt_ext;

  logic signed [36:0]      cprod  [TERMS];
  logic signed [37:0]      csum   [TERMS];
  logic signed [29:0]      crnd   [TERMS];
  logic signed [REM_W:0]   t_nxt  [TERMS];
  logic signed [49:0]      dprod  [TERMS];
  logic signed [50:0]      dsum   [TERMS];
  logic signed [34:0]      drnd   [TERMS];
  logic signed [REM_W-1:0] rem_nxt [TERMS];

  // A term count of three acts as two.
  assign use_term[0] = enable_r && (num_exp_r != '0);
  assign use_term[1] = enable_r && num_exp_r[1];

  // Corrected value: doubled sample in Q16.4 minus the rounded remainder sum.
  always_comb begin
    corr = '0;
    for (int k = 0; k < TERMS; k++) begin
      if (use_term[k]) begin
        corr = corr + {rem_r[k][REM_W-1], rem_r[k]};
      end
    end
    corr_sum = {corr[REM_W], corr} + 34'sd128;
    corr_rnd = corr_sum[33:8];
    gained   = {12'b0, in_adc_sample, 5'b0};
    diff     = gained - {corr_rnd[25], corr_rnd};
    if (!diff[26] && (diff[25:19] != '0)) begin
      res = VAL_MAX;
    end else if (diff[26] && (diff[25:19] != '1)) begin
      res = VAL_MIN;
    end else begin
      res = diff[VAL_W-1:0];
    end
  end

  // Per-term update, split into a coefficient step and a rate step by the t_r register.
  always_comb begin
    for (int k = 0; k < TERMS; k++) begin
      cprod[k] = $signed({1'b0, coef_r[k]}) * res_r;
      csum[k]  = {cprod[k][36], cprod[k]} + 38'sd128;
      crnd[k]  = csum[k][37:8];
      t_nxt[k] = {rem_r[k][REM_W-1], rem_r[k]} + {{3{crnd[k][29]}}, crnd[k]};
      dprod[k] = $signed({1'b0, rate_r[k]}) * t_r[k];
      dsum[k]  = {dprod[k][49], dprod[k]} + 51'sd32768;
      drnd[k]  = dsum[k][50:16];
      if (!drnd[k][34] && (drnd[k][33:31] != '0)) begin
        rem_nxt[k] = REM_MAX;
      end else if (drnd[k][34] && (drnd[k][33:31] != '1)) begin
        rem_nxt[k] = REM_MIN;
      end else begin
        rem_nxt[k] = drnd[k][REM_W-1:0];
      end
    end
  end

  assign cnt_ext = {{TBIN_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= RST_ENABLE;
      num_exp_r <= RST_NUM_EXP;
      rate_r[0] <= RST_RATE_ONE;
      rate_r[1] <= RST_RATE_TWO;
      coef_r[0] <= RST_COEF_ONE;
      coef_r[1] <= RST_COEF_TWO;
      thr_r     <= RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_ENABLE:    enable_r  <= cfg_data[0];
        CFG_IDX_NUM_EXP:   num_exp_r <= cfg_data[NUM_W-1:0];
        CFG_IDX_RATE_ONE:  rate_r[0] <= cfg_data[FAC_W-1:0];
        CFG_IDX_RATE_TWO:  rate_r[1] <= cfg_data[FAC_W-1:0];
        CFG_IDX_COEF_ONE:  coef_r[0] <= cfg_data[FAC_W-1:0];
        CFG_IDX_COEF_TWO:  coef_r[1] <= cfg_data[FAC_W-1:0];
        CFG_IDX_THRESHOLD: thr_r     <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      if (in_last_in_pad || (cnt_r == CW'(MAX_TIME_BINS - 1))) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r  <= res;
      tbin_r <= cnt_ext[TBIN_W-1:0];
      last_r <= in_last_in_pad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.term) begin
      t_r <= t_nxt;
    end
  end

  // Remainders drop to zero at pad end and whenever their term is unused.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r[0] <= '0;
      rem_r[1] <= '0;
    end else if (cmd.decay) begin
      for (int k = 0; k < TERMS; k++) begin
        rem_r[k] <= (use_term[k] && !last_r) ? rem_nxt[k] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_val_r   <= res_r;
      out_tbin_r  <= tbin_r;
      out_above_r <= res_r > $signed({1'b0, thr_r});
      out_last_r  <= last_r;
    end
  end

  assign status.out_free     = !out_valid_r || out_ready;
  assign out_valid           = out_valid_r;
  assign out_filtered_value  = out_val_r;
  assign out_time_bin        = out_tbin_r;
  assign out_above_threshold = out_above_r;
  assign out_last_out        = out_last_r;

  `ETCF_ASSERT_NEXT(a_push_shows, clk, rst_n, cmd.push, out_valid_r,
    "pushed result not shown on the output")
  `ETCF_ASSERT_NEXT(a_pad_end_clears, clk, rst_n, cmd.decay && last_r,
    (rem_r[0] == '0) && (rem_r[1] == '0), "remainders not cleared at pad end")
  `ETCF_ASSERT_NEXT(a_unused_term_zero, clk, rst_n, cmd.decay && !use_term[1],
    rem_r[1] == '0, "unused second remainder is not zero")

endmodule
